// ===== rtl/unfp_pkg.sv =====
// Shared types and constants for the navigation frame parser.
// No dependencies; unfp_parse, unfp_out_stage and ubx_nav_frame_parser import it.
`default_nettype none

package unfp_pkg;

  typedef enum logic [2:0] {
    PH_SYNC1,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PVT,
    KIND_ODO,
    KIND_LLH,
    KIND_NONE
  } kind_t;

  localparam logic [7:0] SYNC_A    = 8'hB5;
  localparam logic [7:0] SYNC_B    = 8'h62;
  localparam logic [7:0] NAV_CLASS = 8'h01;
  localparam logic [7:0] ID_PVT    = 8'h07;
  localparam logic [7:0] ID_ODO    = 8'h09;
  localparam logic [7:0] ID_LLH    = 8'h02;

  // Payload offsets 24..27 (longitude) and 28..31 (latitude), as 4-byte word numbers.
  localparam logic [5:0] LON_WORD = 6'd6;
  localparam logic [5:0] LAT_WORD = 6'd7;

  typedef struct packed {
    logic               frame_done;
    logic               frame_ok;
    kind_t              msg_kind;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
  } res_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] payload_len;
    logic [7:0] byte_count;
  } parse_status_t;

endpackage

`default_nettype wire

// ===== rtl/unfp_byte_if.sv =====
// Valid/ready channel carrying one received byte per item.
// Standalone; used on the input side of ubx_nav_frame_parser.
`default_nettype none

interface unfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/unfp_res_if.sv =====
// Valid/ready channel carrying one parser result per item.
// Standalone; used on the output side of ubx_nav_frame_parser.
`default_nettype none

interface unfp_res_if;
  logic               valid;
  logic               ready;
  logic               frame_done;
  logic               frame_ok;
  logic [1:0]         msg_kind;
  logic signed [31:0] latitude_out;
  logic signed [31:0] longitude_out;

  modport source (output valid, output frame_done, output frame_ok, output msg_kind,
                  output latitude_out, output longitude_out, input ready);
  modport sink   (input valid, input frame_done, input frame_ok, input msg_kind,
                  input latitude_out, input longitude_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/unfp_parse.sv =====
// Frame parser state machine, running Fletcher-8 sum and position capture.
// Depends on unfp_pkg.
`default_nettype none

module unfp_parse
  import unfp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    rx_byte,
  output res_t          res,
  output parse_status_t status
);

  phase_t      phase, phase_next;
  kind_t       kind, kind_next;
  logic [7:0]  payload_len, payload_len_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  sum_a, sum_a_next;
  logic [7:0]  sum_b, sum_b_next;
  logic [7:0]  ck_a, ck_a_next;
  logic [31:0] pend_lat, pend_lat_next;
  logic [31:0] pend_lon, pend_lon_next;
  logic [31:0] lat, lat_next;
  logic [31:0] lon, lon_next;
  logic        ok_flag, ok_flag_next;
  logic        done;

  logic [7:0]  fold_a;
  logic [7:0]  fold_b;
  logic [7:0]  count_inc;
  logic        id_known;
  kind_t       id_kind;
  logic        ck_match;

  assign fold_a    = sum_a + rx_byte;
  assign fold_b    = sum_b + fold_a;
  assign count_inc = byte_count + 8'd1;
  assign ck_match  = (ck_a == sum_a) && (rx_byte == sum_b);

  always_comb begin
    id_known = 1'b1;
    case (rx_byte)
      ID_PVT:  id_kind = KIND_PVT;
      ID_ODO:  id_kind = KIND_ODO;
      ID_LLH:  id_kind = KIND_LLH;
      default: begin
        id_kind  = KIND_NONE;
        id_known = 1'b0;
      end
    endcase
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_SYNC1:   if (rx_byte == SYNC_A) phase_next = PH_SYNC2;
      PH_SYNC2:   phase_next = (rx_byte == SYNC_B) ? PH_CLASS : PH_SYNC1;
      PH_CLASS:   phase_next = (rx_byte == NAV_CLASS) ? PH_ID : PH_SYNC1;
      PH_ID:      phase_next = id_known ? PH_LEN_LO : PH_SYNC1;
      PH_LEN_LO:  phase_next = PH_LEN_HI;
      PH_LEN_HI: begin
        if (rx_byte != 8'd0) phase_next = PH_SYNC1;
        else if (payload_len != 8'd0) phase_next = PH_PAYLOAD;
        else phase_next = PH_CHECK;
      end
      PH_PAYLOAD: if (count_inc == payload_len) phase_next = PH_CHECK;
      PH_CHECK:   if (byte_count != 8'd0) phase_next = PH_SYNC1;
      default:    phase_next = PH_SYNC1;
    endcase
  end

  // Datapath and result
  always_comb begin
    kind_next        = kind;
    payload_len_next = payload_len;
    byte_count_next  = byte_count;
    sum_a_next       = sum_a;
    sum_b_next       = sum_b;
    ck_a_next        = ck_a;
    pend_lat_next    = pend_lat;
    pend_lon_next    = pend_lon;
    lat_next         = lat;
    lon_next         = lon;
    ok_flag_next     = ok_flag;
    done             = 1'b0;
    case (phase)
      PH_SYNC1: begin
        if (rx_byte == SYNC_A) begin
          sum_a_next       = 8'd0;
          sum_b_next       = 8'd0;
          byte_count_next  = 8'd0;
          payload_len_next = 8'd0;
          ok_flag_next     = 1'b0;
          pend_lat_next    = 32'd0;
          pend_lon_next    = 32'd0;
        end
      end
      PH_SYNC2: begin
      end
      PH_CLASS: begin
        if (rx_byte == NAV_CLASS) begin
          sum_a_next = fold_a;
          sum_b_next = fold_b;
        end
      end
      PH_ID: begin
        kind_next = id_kind;
        if (id_known) begin
          sum_a_next = fold_a;
          sum_b_next = fold_b;
        end
      end
      PH_LEN_LO: begin
        payload_len_next = rx_byte;
        sum_a_next       = fold_a;
        sum_b_next       = fold_b;
      end
      PH_LEN_HI: begin
        if (rx_byte == 8'd0) begin
          sum_a_next      = fold_a;
          sum_b_next      = fold_b;
          byte_count_next = 8'd0;
        end
      end
      PH_PAYLOAD: begin
        sum_a_next = fold_a;
        sum_b_next = fold_b;
        if (byte_count[7:2] == LON_WORD)
          pend_lon_next[{byte_count[1:0], 3'b000} +: 8] = rx_byte;
        else if (byte_count[7:2] == LAT_WORD)
          pend_lat_next[{byte_count[1:0], 3'b000} +: 8] = rx_byte;
        byte_count_next = (count_inc == payload_len) ? 8'd0 : count_inc;
      end
      PH_CHECK: begin
        if (byte_count == 8'd0) begin
          ck_a_next       = rx_byte;
          byte_count_next = 8'd1;
        end else begin
          ok_flag_next = ck_match;
          if (ck_match && kind == KIND_PVT) begin
            lat_next = pend_lat;
            lon_next = pend_lon;
          end
          done            = 1'b1;
          byte_count_next = 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.frame_done = done;
  assign res.frame_ok   = ok_flag_next;
  assign res.msg_kind   = kind_next;
  assign res.latitude   = lat_next;
  assign res.longitude  = lon_next;

  assign status.phase       = phase;
  assign status.payload_len = payload_len;
  assign status.byte_count  = byte_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SYNC1;
      kind        <= KIND_NONE;
      payload_len <= 8'd0;
      byte_count  <= 8'd0;
      sum_a       <= 8'd0;
      sum_b       <= 8'd0;
      ck_a        <= 8'd0;
      pend_lat    <= 32'd0;
      pend_lon    <= 32'd0;
      lat         <= 32'd0;
      lon         <= 32'd0;
      ok_flag     <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      kind        <= kind_next;
      payload_len <= payload_len_next;
      byte_count  <= byte_count_next;
      sum_a       <= sum_a_next;
      sum_b       <= sum_b_next;
      ck_a        <= ck_a_next;
      pend_lat    <= pend_lat_next;
      pend_lon    <= pend_lon_next;
      lat         <= lat_next;
      lon         <= lon_next;
      ok_flag     <= ok_flag_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/unfp_out_stage.sv =====
// Result register with valid flag; frees itself in the cycle it is read.
// Depends on unfp_pkg.
`default_nettype none

module unfp_out_stage
  import unfp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t d,
  output logic valid,
  input  logic ready,
  output res_t q,
  output logic space
);

  assign space = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ubx_nav_frame_parser.sv =====
// Byte-serial parser for binary navigation frames (sync B5 62, class, id,
// length, payload, two Fletcher-8 check bytes).
//
// Channels: rx carries one received byte per item; res carries one result
// per accepted byte (frame_done, frame_ok, msg_kind, latitude_out,
// longitude_out). Every byte yields exactly one result, in order.
//
// Each accepted byte's result is held in the result register for res.
// Throughput: one byte per clock while res.ready is high, set by the single
// result register; parser state and checksum update in the accepting cycle.
//
// Stall: rx.ready stays high while the result register is empty or is
// being read in the same cycle. When res.ready holds low with a result
// waiting, rx.ready drops and the parser state holds.
//
// Reset (rst, synchronous): parser hunts for the first sync byte, kind is
// none, checksum, position and flags clear, result register empties.
// Depends on unfp_pkg, unfp_byte_if, unfp_res_if, unfp_parse, unfp_out_stage.
`default_nettype none

module ubx_nav_frame_parser
  import unfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  unfp_byte_if.sink         rx,
  unfp_res_if.source        res
);

  logic          take;
  logic          space;
  res_t          res_d;
  res_t          res_q;
  parse_status_t status;

  // Accept whenever the result register can take the matching result.
  assign rx.ready = space;
  assign take     = rx.valid && space;

  unfp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx.rx_byte),
    .res     (res_d),
    .status  (status)
  );

  unfp_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (take),
    .d     (res_d),
    .valid (res.valid),
    .ready (res.ready),
    .q     (res_q),
    .space (space)
  );

  assign res.frame_done    = res_q.frame_done;
  assign res.frame_ok      = res_q.frame_ok;
  assign res.msg_kind      = res_q.msg_kind;
  assign res.latitude_out  = res_q.latitude;
  assign res.longitude_out = res_q.longitude;

  // Inside a payload the count always trails a nonzero length.
  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    status.phase == PH_PAYLOAD |->
      (status.payload_len != 8'd0) && (status.byte_count < status.payload_len))
    else $error("payload count out of range");

  // Only the two check bytes are counted in the check phase.
  a_check_count: assert property (@(posedge clk) disable iff (rst)
    status.phase == PH_CHECK |-> status.byte_count <= 8'd1)
    else $error("check byte count out of range");

  // A first sync byte clears frame_ok in its own result.
  a_sync_clears_ok: assert property (@(posedge clk) disable iff (rst)
    take && status.phase == PH_SYNC1 && rx.rx_byte == SYNC_A |=>
      res.valid && !res.frame_ok)
    else $error("frame_ok not cleared at sync");

  // A result that is not a frame end never reports a completed check.
  a_done_only_in_check: assert property (@(posedge clk) disable iff (rst)
    take && status.phase != PH_CHECK |=> !res.frame_done)
    else $error("frame_done outside check phase");

endmodule

`default_nettype wire
